@@ hdl/assert_macros.svh @@
// Assertion helpers shared by the top-level and encoder RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, held off while in reset.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, held off while in reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ hdl/sdpe_pkg.sv @@
package sdpe_pkg;

    localparam int unsigned NUM_SWITCHES = 3;

    localparam logic [15:0] MIN_GAP_MS   = 16'd20;
    localparam logic [16:0] INTERVAL_CAP = 17'd65500;
    localparam logic [16:0] TIMER_CAP    = 17'd65535;

    // Configuration register indexes
    localparam logic [2:0] REG_WINDOW_A = 3'd0;
    localparam logic [2:0] REG_WINDOW_B = 3'd1;
    localparam logic [2:0] REG_WINDOW_C = 3'd2;
    localparam logic [2:0] REG_FAST     = 3'd3;
    localparam logic [2:0] REG_MEDIUM   = 3'd4;
    localparam logic [2:0] REG_SLOW     = 3'd5;

    localparam logic [15:0] WINDOW_RESET   = 16'd300;
    localparam logic [15:0] FAST_RESET     = 16'd200;
    localparam logic [15:0] MEDIUM_RESET   = 16'd1500;
    localparam logic [15:0] SLOW_RESET     = 16'd3000;
    localparam logic [15:0] INTERVAL_RESET = 16'd3000;

    // Encoder step codes (2-bit signed)
    localparam logic [1:0] DIR_NONE = 2'b00;
    localparam logic [1:0] DIR_CW   = 2'b01;
    localparam logic [1:0] DIR_CCW  = 2'b11;

    // Speed class codes
    localparam logic [1:0] SPEED_NONE   = 2'd0;
    localparam logic [1:0] SPEED_SLOW   = 2'd1;
    localparam logic [1:0] SPEED_MEDIUM = 2'd2;
    localparam logic [1:0] SPEED_FAST   = 2'd3;

    typedef struct packed {
        logic pressed;
        logic dbl;
    } sw_result_t;

    typedef struct packed {
        logic [15:0] fast;
        logic [15:0] mid;
        logic [15:0] slow;
    } enc_cfg_t;

    typedef struct packed {
        logic [15:0] interval;
        logic [1:0]  speed_class;
        logic [1:0]  direction;
    } enc_result_t;

endpackage

@@ hdl/switch_double_press_and_encoder_tick_unit.sv @@
// Channel  Dir  Width  Contents
// s_*      in   8      one UI tick: switch levels and encoder pins
// m_*      out  32     pressed/double flags, step, speed class, interval
// cfg_*    in   3+16   register index and value, written when cfg_we is high
//
// One tick is accepted per cycle while s_tready is high; its result is registered in the
// output register, computed by the compare/add logic of the switch and encoder state.
// s_tready is low only while a result waits and m_tready is low.
// Reset (rst_n low, asynchronous) clears all but out_reg and loads register defaults.
// State advances only when a tick is accepted, so stalls never drop or repeat results.

`include "assert_macros.svh"

module switch_double_press_and_encoder_tick_unit #(
    parameter int unsigned TICK_MS = 10
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [0] switch_a_level, [1] switch_b_level, [2] switch_c_level,
    // [3] phase_a, [4] phase_b, [7:5] zero
    input  logic [7:0]  s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [0] pressed_a, [1] double_a, [2] pressed_b, [3] double_b, [4] pressed_c,
    // [5] double_c, [7:6] direction, [9:8] speed_class, [25:10] interval, [31:26] zero
    output logic [31:0] m_tdata,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    localparam int unsigned NSW = sdpe_pkg::NUM_SWITCHES;

    logic [15:0]           window_reg [NSW];
    sdpe_pkg::enc_cfg_t    enc_cfg_reg;
    sdpe_pkg::sw_result_t  sw_res [NSW];
    sdpe_pkg::enc_result_t enc_res;
    logic                  take;
    logic                  out_valid_reg;
    logic [25:0]           out_reg;
    logic [25:0]           out_next;

    assign s_tready = !out_valid_reg || m_tready;
    assign take     = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NSW; i++)
            begin
                window_reg[i] <= sdpe_pkg::WINDOW_RESET;
            end
            enc_cfg_reg.fast <= sdpe_pkg::FAST_RESET;
            enc_cfg_reg.mid  <= sdpe_pkg::MEDIUM_RESET;
            enc_cfg_reg.slow <= sdpe_pkg::SLOW_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                sdpe_pkg::REG_WINDOW_A: window_reg[0] <= cfg_data;
                sdpe_pkg::REG_WINDOW_B: window_reg[1] <= cfg_data;
                sdpe_pkg::REG_WINDOW_C: window_reg[2] <= cfg_data;
                sdpe_pkg::REG_FAST:     enc_cfg_reg.fast <= cfg_data;
                sdpe_pkg::REG_MEDIUM:   enc_cfg_reg.mid  <= cfg_data;
                sdpe_pkg::REG_SLOW:     enc_cfg_reg.slow <= cfg_data;
                default: ;
            endcase
        end
    end

    for (genvar g = 0; g < NSW; g++)
    begin : g_sw
        sdpe_switch #(
            .TICK_MS (TICK_MS)
        ) u_switch (
            .clk    (clk),
            .rst_n  (rst_n),
            .take   (take),
            .level  (s_tdata[g]),
            .window (window_reg[g]),
            .result (sw_res[g])
        );
    end

    sdpe_encoder #(
        .TICK_MS (TICK_MS)
    ) u_encoder (
        .clk     (clk),
        .rst_n   (rst_n),
        .take    (take),
        .phase_a (s_tdata[3]),
        .phase_b (s_tdata[4]),
        .cfg     (enc_cfg_reg),
        .result  (enc_res)
    );

    assign out_next = {enc_res.interval, enc_res.speed_class, enc_res.direction,
                       sw_res[2].dbl, sw_res[2].pressed,
                       sw_res[1].dbl, sw_res[1].pressed,
                       sw_res[0].dbl, sw_res[0].pressed};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (take)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // hold the word while the sink stalls
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            out_reg <= out_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0, out_reg};

    `ASSERT_NEXT(a_take_gives_word, clk, rst_n, take, m_tvalid)
    `ASSERT_IMPLIES(a_double_needs_press, clk, rst_n, m_tvalid,
        (m_tdata[1] == 1'b0 || m_tdata[0]) && (m_tdata[3] == 1'b0 || m_tdata[2])
        && (m_tdata[5] == 1'b0 || m_tdata[4]))
    `ASSERT_IMPLIES(a_direction_code, clk, rst_n, m_tvalid, m_tdata[7:6] != 2'b10)

endmodule

@@ hdl/sdpe_switch.sv @@
module sdpe_switch #(
    parameter int unsigned TICK_MS = 10
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  take,
    input  logic                  level,
    input  logic [15:0]           window,
    output sdpe_pkg::sw_result_t  result
);

    logic        pressed_reg;
    logic        pressed_next;
    logic [15:0] timer_reg;
    logic [15:0] timer_next;
    logic        changed;
    logic        restart;
    logic        dbl;
    logic [16:0] sum;

    always_comb
    begin
        pressed_next = ~level;
        changed      = (pressed_next != pressed_reg);
        restart      = 1'b0;
        dbl          = 1'b0;
        if (!pressed_next && changed && (timer_reg >= window))
        begin
            restart = 1'b1;
        end
        else if (pressed_next && changed && (timer_reg <= window)
                 && (timer_reg >= sdpe_pkg::MIN_GAP_MS))
        begin
            restart = 1'b1;
            dbl     = 1'b1;
        end
        sum = (restart ? 17'd0 : {1'b0, timer_reg}) + 17'(TICK_MS);
        // saturate the gap timer
        if (sum > sdpe_pkg::TIMER_CAP)
        begin
            timer_next = sdpe_pkg::TIMER_CAP[15:0];
        end
        else
        begin
            timer_next = sum[15:0];
        end
    end

    assign result.pressed = pressed_next;
    assign result.dbl     = dbl;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pressed_reg <= 1'b0;
            timer_reg   <= 16'd0;
        end
        else if (take)
        begin
            pressed_reg <= pressed_next;
            timer_reg   <= timer_next;
        end
    end

endmodule

@@ hdl/sdpe_encoder.sv @@
`include "assert_macros.svh"

module sdpe_encoder #(
    parameter int unsigned TICK_MS = 10
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   take,
    input  logic                   phase_a,
    input  logic                   phase_b,
    input  sdpe_pkg::enc_cfg_t     cfg,
    output sdpe_pkg::enc_result_t  result
);

    logic [15:0] edge_reg;
    logic [15:0] edge_next;
    logic [15:0] prev_reg;
    logic        saved_a_reg;
    logic [16:0] cnt;
    logic [15:0] cnt_sat;
    logic        step;

    always_comb
    begin
        cnt = {1'b0, edge_reg} + 17'(TICK_MS);
        if (cnt >= sdpe_pkg::INTERVAL_CAP)
        begin
            cnt_sat = sdpe_pkg::INTERVAL_CAP[15:0];
        end
        else
        begin
            cnt_sat = cnt[15:0];
        end
        step = (phase_a != phase_b) && (cnt_sat >= cfg.fast);
        // rebase against the interval of the previous edge, wrapping mod 2^16
        edge_next = step ? (cnt_sat - prev_reg) : cnt_sat;

        if (!step)
        begin
            result.direction = sdpe_pkg::DIR_NONE;
        end
        else if (saved_a_reg == phase_b)
        begin
            result.direction = sdpe_pkg::DIR_CCW;
        end
        else
        begin
            result.direction = sdpe_pkg::DIR_CW;
        end

        if (edge_next <= cfg.fast)
        begin
            result.speed_class = sdpe_pkg::SPEED_FAST;
        end
        else if (edge_next <= cfg.mid)
        begin
            result.speed_class = sdpe_pkg::SPEED_MEDIUM;
        end
        else if (edge_next <= cfg.slow)
        begin
            result.speed_class = sdpe_pkg::SPEED_SLOW;
        end
        else
        begin
            result.speed_class = sdpe_pkg::SPEED_NONE;
        end
        result.interval = edge_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            edge_reg    <= sdpe_pkg::INTERVAL_RESET;
            prev_reg    <= sdpe_pkg::INTERVAL_RESET;
            saved_a_reg <= 1'b0;
        end
        else if (take)
        begin
            edge_reg <= edge_next;
            if (step)
            begin
                prev_reg    <= edge_next;
                saved_a_reg <= phase_a;
            end
        end
    end

    `ASSERT_NEXT(a_edge_saves_prev, clk, rst_n, take && step, prev_reg == edge_reg)
    `ASSERT_NEXT(a_edge_saves_phase, clk, rst_n, take && step, saved_a_reg == $past(phase_a))
    `ASSERT_NEXT(a_no_edge_counts, clk, rst_n, take && !step, edge_reg == $past(cnt_sat))

endmodule

@@ test/tb.sv @@
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned TICK_MS = 10;

    // Unused indexes: writes there must leave the registers alone
    localparam logic [2:0] REG_SPARE_A = 3'd6;
    localparam logic [2:0] REG_SPARE_B = 3'd7;

    // Mirrors the m_tdata layout from bit 31 down to bit 0
    typedef struct packed {
        logic [5:0]  pad;
        logic [15:0] interval;
        logic [1:0]  speed_class;
        logic [1:0]  direction;
        logic        dbl_c;
        logic        pr_c;
        logic        dbl_b;
        logic        pr_b;
        logic        dbl_a;
        logic        pr_a;
    } tick_result_t;

    class tick_scoreboard;
        logic [15:0]  window [3];
        logic [15:0]  fast_thr;
        logic [15:0]  medium_thr;
        logic [15:0]  slow_thr;
        logic [2:0]   pressed;
        logic [15:0]  gap [3];
        logic [15:0]  edge_ivl;
        logic [15:0]  prev_ivl;
        logic         last_pa;
        tick_result_t pending_results [$];
        int           errors;

        function void reset_state();
            for (int i = 0; i < 3; i++)
            begin
                window[i] = sdpe_pkg::WINDOW_RESET;
                gap[i] = '0;
            end
            fast_thr = sdpe_pkg::FAST_RESET;
            medium_thr = sdpe_pkg::MEDIUM_RESET;
            slow_thr = sdpe_pkg::SLOW_RESET;
            pressed = '0;
            edge_ivl = sdpe_pkg::INTERVAL_RESET;
            prev_ivl = sdpe_pkg::INTERVAL_RESET;
            last_pa = 1'b0;
            errors = 0;
        endfunction

        function void set_reg(logic [2:0] idx, logic [15:0] v);
            case (idx)
                sdpe_pkg::REG_WINDOW_A: window[0] = v;
                sdpe_pkg::REG_WINDOW_B: window[1] = v;
                sdpe_pkg::REG_WINDOW_C: window[2] = v;
                sdpe_pkg::REG_FAST:     fast_thr = v;
                sdpe_pkg::REG_MEDIUM:   medium_thr = v;
                sdpe_pkg::REG_SLOW:     slow_thr = v;
                default:      ;
            endcase
        endfunction

        function int outstanding();
            return pending_results.size();
        endfunction

        // f: {phase_b, phase_a, switch_c_level, switch_b_level, switch_a_level}
        function void accept_tick(logic [4:0] f);
            tick_result_t r;
            logic [16:0]  sum;
            logic [15:0]  t;
            logic [2:0]   dbl;
            logic         now;
            logic         changed;
            r = '0;
            dbl = '0;

            sum = {1'b0, edge_ivl} + 17'(TICK_MS);
            edge_ivl = (sum >= sdpe_pkg::INTERVAL_CAP) ? sdpe_pkg::INTERVAL_CAP[15:0]
                : sum[15:0];
            r.direction = sdpe_pkg::DIR_NONE;
            if (f[3] != f[4] && edge_ivl >= fast_thr)
            begin
                // rebase against the interval kept from the previous edge, wrapping
                edge_ivl = edge_ivl - prev_ivl;
                prev_ivl = edge_ivl;
                r.direction = (last_pa == f[4]) ? sdpe_pkg::DIR_CCW : sdpe_pkg::DIR_CW;
                last_pa = f[3];
            end
            if (edge_ivl <= fast_thr)
                r.speed_class = sdpe_pkg::SPEED_FAST;
            else if (edge_ivl <= medium_thr)
                r.speed_class = sdpe_pkg::SPEED_MEDIUM;
            else if (edge_ivl <= slow_thr)
                r.speed_class = sdpe_pkg::SPEED_SLOW;
            else
                r.speed_class = sdpe_pkg::SPEED_NONE;
            r.interval = edge_ivl;

            for (int i = 0; i < 3; i++)
            begin
                now = ~f[i];
                changed = (now != pressed[i]);
                pressed[i] = now;
                t = gap[i];
                if (!now && changed && t >= window[i])
                    t = '0;
                else if (now && changed && t <= window[i] && t >= sdpe_pkg::MIN_GAP_MS)
                begin
                    t = '0;
                    dbl[i] = 1'b1;
                end
                sum = {1'b0, t} + 17'(TICK_MS);
                gap[i] = (sum > sdpe_pkg::TIMER_CAP) ? 16'hFFFF : sum[15:0];
            end
            r.pr_a = pressed[0];
            r.dbl_a = dbl[0];
            r.pr_b = pressed[1];
            r.dbl_b = dbl[1];
            r.pr_c = pressed[2];
            r.dbl_c = dbl[2];
            pending_results.push_back(r);
        endfunction

        function void compare_field(string name, int unsigned want, int unsigned got);
            if (want != got)
            begin
                if (errors < 50)
                    $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want,
                        got);
                errors++;
            end
        endfunction

        function void check_tick(logic [31:0] word);
            tick_result_t got;
            tick_result_t want;
            got = word;
            if (pending_results.size() == 0)
            begin
                if (errors < 50)
                    $display("%0t: unexpected word, expected none, actual %h", $time, word);
                errors++;
                return;
            end
            want = pending_results.pop_front();
            compare_field("pressed_a", want.pr_a, got.pr_a);
            compare_field("double_a", want.dbl_a, got.dbl_a);
            compare_field("pressed_b", want.pr_b, got.pr_b);
            compare_field("double_b", want.dbl_b, got.dbl_b);
            compare_field("pressed_c", want.pr_c, got.pr_c);
            compare_field("double_c", want.dbl_c, got.dbl_c);
            compare_field("direction", want.direction, got.direction);
            compare_field("speed_class", want.speed_class, got.speed_class);
            compare_field("interval", want.interval, got.interval);
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [15:0] cfg_data;

    tick_scoreboard sb;

    logic        tx_random;
    logic        rx_random;
    int          rx_hold_len;
    logic [15:0] plan [6];

    // Random tick generator state
    logic [2:0]  sw_level;
    int          sw_run [3];
    logic [1:0]  enc_pos;
    int          enc_dwell;
    logic        enc_cw;

    logic [4:0] directed [20] = '{
        5'b00111, 5'b00000, 5'b01000, 5'b11111, 5'b10000,
        5'b10111, 5'b00110, 5'b00110, 5'b00111, 5'b01101,
        5'b01101, 5'b00111, 5'b10011, 5'b11111, 5'b01010,
        5'b00111, 5'b11101, 5'b00111, 5'b10111, 5'b01000
    };

    switch_double_press_and_encoder_tick_unit #(
        .TICK_MS(TICK_MS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #20ms;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    function int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                sb.accept_tick(s_tdata[4:0]);
            if (m_tvalid && m_tready)
                sb.check_tick(m_tdata);
        end
    end

    // Result side: random stalls, plus a long hold-off on request
    initial
    begin
        int hold_cnt;
        int stall_cnt;
        hold_cnt = 0;
        stall_cnt = 0;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (rx_hold_len != 0)
            begin
                hold_cnt = rx_hold_len;
                rx_hold_len = 0;
            end
            if (hold_cnt != 0)
            begin
                m_tready <= 1'b0;
                hold_cnt--;
            end
            else if (!rx_random)
                m_tready <= 1'b1;
            else if (stall_cnt != 0)
            begin
                m_tready <= 1'b0;
                stall_cnt--;
            end
            else
            begin
                stall_cnt = pick_gap();
                m_tready <= (stall_cnt == 0);
            end
        end
    end

    // Called at a falling edge; returns at a falling edge with no pending change
    task send_tick(input logic [4:0] f);
        int gap_len;
        s_tdata <= {3'b000, f};
        s_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_tready);
        @(negedge clk);
        gap_len = tx_random ? pick_gap() : 0;
        if (gap_len != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap_len) @(negedge clk);
        end
    endtask

    task drain();
        s_tvalid <= 1'b0;
        do
            @(negedge clk);
        while (sb.outstanding() != 0);
    endtask

    task program_regs();
        logic [2:0]  idx [8];
        logic [15:0] val;
        int          i;
        idx = '{sdpe_pkg::REG_WINDOW_A, sdpe_pkg::REG_WINDOW_B, sdpe_pkg::REG_WINDOW_C,
            sdpe_pkg::REG_FAST, sdpe_pkg::REG_MEDIUM, sdpe_pkg::REG_SLOW,
            REG_SPARE_A, REG_SPARE_B};
        drain();
        repeat (2) @(negedge clk);
        for (i = 0; i < 8; i++)
        begin
            val = (i < 6) ? plan[i] : 16'($urandom);
            cfg_we <= 1'b1;
            cfg_index <= idx[i];
            cfg_data <= val;
            sb.set_reg(idx[i], val);
            @(negedge clk);
        end
        cfg_we <= 1'b0;
    endtask

    task make_plan(input int p);
        case (p)
            0: plan = '{16'd40, 16'd150, 16'd65535, 16'd0, 16'd60, 16'd120};
            1: plan = '{16'd0, 16'd65535, 16'd20, 16'd65535, 16'd0, 16'd0};
            2:
            begin
                plan[0] = 16'($urandom_range(20, 400));
                plan[1] = 16'($urandom_range(20, 400));
                plan[2] = 16'($urandom_range(20, 400));
                plan[3] = 16'($urandom_range(0, 300));
                plan[4] = plan[3] + 16'($urandom_range(0, 1500));
                plan[5] = plan[4] + 16'($urandom_range(0, 3000));
            end
            3:
            begin
                // unordered thresholds, anything goes
                for (int i = 0; i < 6; i++)
                    plan[i] = 16'($urandom_range(0, 65535));
            end
            default: plan = '{sdpe_pkg::WINDOW_RESET, sdpe_pkg::WINDOW_RESET,
                sdpe_pkg::WINDOW_RESET, sdpe_pkg::FAST_RESET,
                sdpe_pkg::MEDIUM_RESET, sdpe_pkg::SLOW_RESET};
        endcase
    endtask

    // Switches toggle in runs that mostly fit the press window; encoder walks gray code
    task gen_tick(output logic [4:0] f);
        int i;
        for (i = 0; i < 3; i++)
        begin
            if (sw_run[i] == 0)
            begin
                sw_level[i] = ~sw_level[i];
                sw_run[i] = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 90)
                    : $urandom_range(1, 35);
            end
            else
                sw_run[i]--;
        end
        if (enc_dwell == 0)
        begin
            if ($urandom_range(0, 9) == 0)
                enc_cw = ~enc_cw;
            enc_pos = enc_cw ? enc_pos + 2'd1 : enc_pos - 2'd1;
            if ($urandom_range(0, 19) == 0)
                enc_pos = 2'($urandom_range(0, 3));
            enc_dwell = ($urandom_range(0, 9) == 0) ? $urandom_range(26, 300)
                : $urandom_range(0, 25);
        end
        else
            enc_dwell--;
        f = {enc_pos ^ (enc_pos >> 1), sw_level};
        // occasional noise word
        if ($urandom_range(0, 11) == 0)
            f = 5'($urandom);
    endtask

    initial
    begin
        logic [4:0] f;
        int         p;
        int         n;
        int         wait_cnt;
        sb = new;
        sb.reset_state();
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        tx_random = 1'b1;
        rx_random = 1'b1;
        rx_hold_len = 0;
        sw_level = 3'b111;
        for (n = 0; n < 3; n++)
            sw_run[n] = $urandom_range(0, 20);
        enc_pos = '0;
        enc_dwell = 0;
        enc_cw = 1'b1;

        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (directed[i])
            send_tick(directed[i]);

        // Hold everything still for a short back-to-back stretch
        tx_random = 1'b0;
        repeat (30) send_tick(5'b00111);
        tx_random = 1'b1;

        for (p = 0; p < 5; p++)
        begin
            make_plan(p);
            program_regs();
            tx_random = (p != 3);
            rx_random = (p != 3);
            for (n = 0; n < 90; n++)
            begin
                if (p == 1 && n == 20)
                    rx_hold_len = 300;
                if (p == 2 && n == 45)
                    drain();
                gen_tick(f);
                send_tick(f);
            end
        end

        s_tvalid <= 1'b0;
        rx_random = 1'b0;
        wait_cnt = 0;
        while (sb.outstanding() != 0 && wait_cnt < 20000)
        begin
            @(negedge clk);
            wait_cnt++;
        end
        repeat (5) @(negedge clk);
        if (sb.outstanding() != 0)
        begin
            $display("%0t: %0d results missing, expected 0 left, actual %0d", $time,
                sb.outstanding(), sb.outstanding());
            sb.errors++;
        end
        if (sb.errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
